FILE: design/hash_match_run_detector_macros.svh
// assertion macros for the hash match run detector
`ifndef HASH_MATCH_RUN_DETECTOR_MACROS_SVH
`define HASH_MATCH_RUN_DETECTOR_MACROS_SVH

`ifndef SYNTH
`define HMRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HMRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HMRD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define HMRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/hmrd_pkg.sv
package hmrd_pkg;

  localparam int MAX_ASSET_FRAMES_DEF = 1024;
  localparam int WINDOW_DEF           = 16;
  localparam int HASH_BITS_DEF        = 64;

  localparam int HASH_W   = 64;
  localparam int INDEX_W  = 10;
  localparam int DIST_W   = 7;
  localparam int FRAME_W  = 24;
  localparam int RUN_W    = 12;
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 2;

  localparam int ASSET_CNT_W = 11;
  localparam int MAX_DSUM_W  = 11;
  localparam int MAX_SPR_W   = 21;
  localparam int MIN_RUN_W   = 12;

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPARE = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ASSET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DSUM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPREAD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN     = 2'd3;

  localparam logic [ASSET_CNT_W-1:0] ASSET_COUNT_RST = 11'd1;
  localparam logic [MAX_DSUM_W-1:0]  MAX_DSUM_RST    = 11'd116;
  localparam logic [MAX_SPR_W-1:0]   MAX_SPREAD_RST  = 21'd5139;
  localparam logic [MIN_RUN_W-1:0]   MIN_RUN_RST     = 12'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_ACC,
    ST_MUL,
    ST_JUDGE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic read;
    logic acc;
    logic mul;
    logic judge;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic pipe_empty;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: design/hash_match_run_detector.sv
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   action, hash, asset_index
// out       output     out_valid/out_stall min_distance, window_valid, window_good,
//                                          match_found, match_frame
// cfg       input      cfg_we              cfg_index, cfg_data
//
// load and restart act in the cycle they are taken; a compare scans min(asset_count,
// table depth) table entries, one per cycle through the single read port, then passes
// the tail, accumulate, multiply and judge steps before the next transaction is taken
// a new transaction is taken while a finished result waits in the output register;
// a compare holds in its last step while out_stall keeps that result pending
// synchronous reset clears the stream state and loads the register defaults, not the table
module hash_match_run_detector import hmrd_pkg::*; #(
  parameter int MAX_ASSET_FRAMES = MAX_ASSET_FRAMES_DEF,
  parameter int WINDOW           = WINDOW_DEF,
  parameter int HASH_BITS        = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [HASH_W-1:0]    hash,
  input  logic [INDEX_W-1:0]   asset_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    min_distance,
  output logic                 window_valid,
  output logic                 window_good,
  output logic                 match_found,
  output logic [FRAME_W-1:0]   match_frame
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hmrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hmrd_dp #(
    .MAX_ASSET_FRAMES (MAX_ASSET_FRAMES),
    .WINDOW           (WINDOW),
    .HASH_BITS        (HASH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .hash         (hash),
    .asset_index  (asset_index),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .min_distance (min_distance),
    .window_valid (window_valid),
    .window_good  (window_good),
    .match_found  (match_found),
    .match_frame  (match_frame)
  );

endmodule

FILE: design/hmrd_ctrl.sv
module hmrd_ctrl import hmrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  dp_status_t status,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (action)
            ACT_LOAD: begin
              cmd.load = 1'b1;
            end
            ACT_RESTART: begin
              cmd.clear = 1'b1;
            end
            ACT_COMPARE: begin
              cmd.start  = 1'b1;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          cmd.read = 1'b1;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (status.pipe_empty) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (!status.out_busy) begin
          cmd.judge  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/hmrd_dp.sv
`include "hash_match_run_detector_macros.svh"

module hmrd_dp import hmrd_pkg::*; #(
  parameter int MAX_ASSET_FRAMES = MAX_ASSET_FRAMES_DEF,
  parameter int WINDOW           = WINDOW_DEF,
  parameter int HASH_BITS        = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [HASH_W-1:0]    hash,
  input  logic [INDEX_W-1:0]   asset_index,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [DIST_W-1:0]    min_distance,
  output logic                 window_valid,
  output logic                 window_good,
  output logic                 match_found,
  output logic [FRAME_W-1:0]   match_frame
);

  localparam int TAB_AW  = (MAX_ASSET_FRAMES > 1) ? $clog2(MAX_ASSET_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_ASSET_FRAMES + 1);
  localparam int RING_AW = $clog2(WINDOW);
  localparam int DSUM_W  = $clog2(WINDOW * HASH_BITS + 1);
  localparam int SQ_W    = $clog2(WINDOW * HASH_BITS * HASH_BITS + 1);
  localparam int WQ_W    = SQ_W + $clog2(WINDOW + 1);
  localparam int SS_W    = 2 * DSUM_W;
  localparam int SPR_A   = (WQ_W > SS_W) ? WQ_W : SS_W;
  localparam int SPR_W   = (SPR_A > MAX_SPR_W) ? SPR_A : MAX_SPR_W;
  localparam int DCMP_W  = (DSUM_W > MAX_DSUM_W) ? DSUM_W : MAX_DSUM_W;
  localparam int HALF_WIN = WINDOW / 2;
  localparam logic [HASH_W-1:0] HMASK =
    (HASH_BITS >= HASH_W) ? {HASH_W{1'b1}} : ((HASH_W'(1) << HASH_BITS) - HASH_W'(1));

  function automatic logic [DIST_W-1:0] popcount(input logic [HASH_W-1:0] x);
    logic [DIST_W-1:0] acc [HASH_W];
    for (int i = 0; i < HASH_W; i++) begin
      acc[i] = DIST_W'(x[i]);
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int j = 0; j < (HASH_W >> (lvl + 1)); j++) begin
        acc[j] = acc[2*j] + acc[2*j+1];
      end
    end
    return acc[0];
  endfunction

  logic [ASSET_CNT_W-1:0] asset_count;
  logic [MAX_DSUM_W-1:0]  max_dsum;
  logic [MAX_SPR_W-1:0]   max_spread;
  logic [MIN_RUN_W-1:0]   min_run;

  logic [HASH_W-1:0] ref_mem [MAX_ASSET_FRAMES];
  logic [DIST_W-1:0] ring_mem [WINDOW];

  logic [HASH_W-1:0]  hash_m;
  logic [HASH_W-1:0]  hash_q;
  logic [HASH_W-1:0]  ref_rd;
  logic               load_ok;
  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   addr;
  logic               scan_more;
  logic               v1;
  logic               v2;
  logic [DIST_W-1:0]  dist_q;
  logic [DIST_W-1:0]  best;
  logic [DIST_W-1:0]  old_q;
  logic [RING_AW-1:0] pos;

  logic [DSUM_W-1:0]  dsum;
  logic [SQ_W-1:0]    sq_sum;
  logic [FRAME_W-1:0] frame_count;
  logic [RUN_W-1:0]   run_length;
  logic [FRAME_W-1:0] run_start;
  logic               match_latched;
  logic [FRAME_W-1:0] found_frame;
  logic [WQ_W-1:0]    wq;
  logic [SS_W-1:0]    ss;

  logic                full;
  logic [2*DIST_W-1:0] best_sq;
  logic [2*DIST_W-1:0] old_sq;
  logic [DSUM_W:0]     dsum_ext;
  logic [SQ_W:0]       sq_ext;

  logic [SPR_W-1:0]   spread;
  logic               good;
  logic [MIN_RUN_W-1:0] min_eff;
  logic [RUN_W-1:0]   run_length_next;
  logic [FRAME_W-1:0] run_start_next;
  logic               match_latched_next;
  logic [FRAME_W-1:0] found_frame_next;
  logic [FRAME_W:0]   found_sum;

  assign hash_m    = hash & HMASK;
  assign load_ok   = (17'(asset_index) < 17'(MAX_ASSET_FRAMES));
  assign count_eff = (17'(asset_count) > 17'(MAX_ASSET_FRAMES)) ?
                     CNT_W'(MAX_ASSET_FRAMES) : CNT_W'(asset_count);
  assign scan_more = (addr < count_eff);

  assign status.scan_more  = scan_more;
  assign status.pipe_empty = !v1 && !v2;
  assign status.out_busy   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      asset_count <= ASSET_COUNT_RST;
      max_dsum    <= MAX_DSUM_RST;
      max_spread  <= MAX_SPREAD_RST;
      min_run     <= MIN_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ASSET_COUNT: asset_count <= cfg_data[ASSET_CNT_W-1:0];
        REG_MAX_DSUM:    max_dsum    <= cfg_data[MAX_DSUM_W-1:0];
        REG_MAX_SPREAD:  max_spread  <= cfg_data[MAX_SPR_W-1:0];
        REG_MIN_RUN:     min_run     <= cfg_data[MIN_RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // reference table
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      ref_mem[TAB_AW'(asset_index)] <= hash_m;
    end
    if (cmd.read) begin
      ref_rd <= ref_mem[addr[TAB_AW-1:0]];
    end
  end

  // recent distance ring
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      ring_mem[pos] <= best;
    end
    if (cmd.start) begin
      old_q <= ring_mem[pos];
    end
  end

  // scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      addr <= '0;
    end else begin
      v1 <= cmd.read;
      v2 <= v1;
      if (cmd.start) begin
        addr <= '0;
      end else if (cmd.read) begin
        addr <= addr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hash_q <= hash_m;
      best   <= DIST_W'(HASH_BITS);
    end else if (v2 && (dist_q < best)) begin
      best <= dist_q;
    end
    if (v1) begin
      dist_q <= popcount(ref_rd ^ hash_q);
    end
  end

  // window sums
  assign full    = (frame_count >= FRAME_W'(WINDOW));
  assign best_sq = (2*DIST_W)'(best) * (2*DIST_W)'(best);
  assign old_sq  = (2*DIST_W)'(old_q) * (2*DIST_W)'(old_q);

  always_comb begin
    dsum_ext = (DSUM_W+1)'(dsum) + (DSUM_W+1)'(best);
    sq_ext   = (SQ_W+1)'(sq_sum) + (SQ_W+1)'(best_sq);
    if (full) begin
      dsum_ext = dsum_ext - (DSUM_W+1)'(old_q);
      sq_ext   = sq_ext - (SQ_W+1)'(old_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      wq <= WQ_W'(sq_sum) * WQ_W'(WINDOW);
      ss <= SS_W'(dsum) * SS_W'(dsum);
    end
  end

  // window judgement and run tracking
  always_comb begin
    spread = SPR_W'(wq) - SPR_W'(ss);
    good   = full && (DCMP_W'(dsum) < DCMP_W'(max_dsum)) &&
             (spread < SPR_W'(max_spread));
    min_eff = (min_run == '0) ? MIN_RUN_W'(1) : min_run;
    run_length_next    = run_length;
    run_start_next     = run_start;
    match_latched_next = match_latched;
    found_frame_next   = found_frame;
    found_sum          = '0;
    if (good) begin
      if (run_length == '0) begin
        run_start_next = frame_count - FRAME_W'(WINDOW);
      end
      if (run_length != RUN_MAX) begin
        run_length_next = run_length + RUN_W'(1);
      end
      if (!match_latched && (run_length_next >= min_eff)) begin
        found_sum          = (FRAME_W+1)'(run_start_next) + (FRAME_W+1)'(HALF_WIN);
        match_latched_next = 1'b1;
        found_frame_next   = found_sum[FRAME_W] ? FRAME_MAX : found_sum[FRAME_W-1:0];
      end
    end else begin
      run_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pos           <= '0;
      dsum          <= '0;
      sq_sum        <= '0;
      frame_count   <= '0;
      run_length    <= '0;
      run_start     <= '0;
      match_latched <= 1'b0;
      found_frame   <= '0;
    end else begin
      if (cmd.acc) begin
        dsum   <= dsum_ext[DSUM_W-1:0];
        sq_sum <= sq_ext[SQ_W-1:0];
        pos    <= (pos == RING_AW'(WINDOW - 1)) ? '0 : pos + RING_AW'(1);
        if (frame_count != FRAME_MAX) begin
          frame_count <= frame_count + FRAME_W'(1);
        end
      end
      if (cmd.judge) begin
        run_length    <= run_length_next;
        run_start     <= run_start_next;
        match_latched <= match_latched_next;
        found_frame   <= found_frame_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.judge) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      min_distance <= best;
      window_valid <= full;
      window_good  <= good;
      match_found  <= match_latched_next;
      match_frame  <= match_latched_next ? found_frame_next : '0;
    end
  end

  `HMRD_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.judge, !(out_valid && out_stall), "result overwritten while pending")
  `HMRD_ASSERT_NOW(a_read_in_range, clk, rst, cmd.read, scan_more, "table read past asset count")
  `HMRD_ASSERT_NOW(a_run_needs_window, clk, rst, run_length != '0, frame_count >= FRAME_W'(WINDOW), "run without full window")
  `HMRD_ASSERT_NEXT(a_latch_holds, clk, rst, match_latched && !cmd.clear, match_latched && $stable(found_frame), "latched match changed")

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hmrd_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int TABLE_DEPTH = MAX_ASSET_FRAMES_DEF;
  localparam int FILL_DEPTH  = 48;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] SPREAD_TOP = '1;

  typedef struct packed {
    logic [DIST_W-1:0]  min_distance;
    logic               window_valid;
    logic               window_good;
    logic               match_found;
    logic [FRAME_W-1:0] match_frame;
  } frame_verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_LOAD;
  logic [HASH_W-1:0]    hash = '0;
  logic [INDEX_W-1:0]   asset_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DIST_W-1:0]    min_distance;
  logic                 window_valid;
  logic                 window_good;
  logic                 match_found;
  logic [FRAME_W-1:0]   match_frame;

  hash_match_run_detector DUT (.*);

  // reference table and stream state as the block should hold them
  logic [HASH_W-1:0] ref_table [TABLE_DEPTH];
  int unsigned recent_dist [WIN];
  int unsigned ring_wr, dist_sum, sq_sum, frames_seen, run_len, run_first, found_at;
  bit          latched;
  int unsigned cfg_assets       = ASSET_COUNT_RST;
  int unsigned cfg_dsum_limit   = MAX_DSUM_RST;
  int unsigned cfg_spread_limit = MAX_SPREAD_RST;
  int unsigned cfg_run_min      = MIN_RUN_RST;

  frame_verdict_t expected_verdicts [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent, verdicts_checked, good_windows, matched_verdicts;
  int unsigned fail_count;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void clear_stream();
    foreach (recent_dist[i]) recent_dist[i] = 0;
    ring_wr     = 0;
    dist_sum    = 0;
    sq_sum      = 0;
    frames_seen = 0;
    run_len     = 0;
    run_first   = 0;
    latched     = 1'b0;
    found_at    = 0;
  endfunction

  function automatic logic [HASH_W-1:0] perturb(input logic [HASH_W-1:0] h,
                                                input int unsigned flips);
    int unsigned b;
    for (int j = 0; j < flips; j++) begin
      b = $urandom_range(HASH_W - 1);
      h[b] = ~h[b];
    end
    return h;
  endfunction

  task automatic predict_transaction(input logic [1:0] act, input logic [HASH_W-1:0] h,
                                     input logic [INDEX_W-1:0] idx);
    int unsigned scan, best, d, old, spread;
    bit good;
    frame_verdict_t v;
    case (act)
      ACT_LOAD: ref_table[idx] = h;
      ACT_RESTART: clear_stream();
      ACT_COMPARE: begin
        scan = (cfg_assets > TABLE_DEPTH) ? TABLE_DEPTH : cfg_assets;
        best = HASH_BITS_DEF;
        for (int i = 0; i < scan; i++) begin
          d = $countones(ref_table[i] ^ h);
          if (d < best) best = d;
        end
        if (frames_seen >= WIN) begin
          old = recent_dist[ring_wr];
          dist_sum -= old;
          sq_sum -= old * old;
        end
        recent_dist[ring_wr] = best;
        dist_sum += best;
        sq_sum += best * best;
        ring_wr = (ring_wr + 1) % WIN;
        if (frames_seen < FRAME_MAX) frames_seen++;
        good = 1'b0;
        if (frames_seen >= WIN) begin
          spread = WIN * sq_sum - dist_sum * dist_sum;
          good = (dist_sum < cfg_dsum_limit) && (spread < cfg_spread_limit);
        end
        if (good) begin
          if (run_len == 0) run_first = frames_seen - WIN;
          if (run_len < RUN_MAX) run_len++;
          if (!latched && run_len >= cfg_run_min) begin
            latched  = 1'b1;
            found_at = (run_first + WIN / 2 > FRAME_MAX) ? FRAME_MAX : run_first + WIN / 2;
          end
        end else begin
          run_len = 0;
        end
        v.min_distance = DIST_W'(best);
        v.window_valid = (frames_seen >= WIN);
        v.window_good  = good;
        v.match_found  = latched;
        v.match_frame  = latched ? FRAME_W'(found_at) : '0;
        expected_verdicts.push_back(v);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] act, input logic [HASH_W-1:0] h,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    hash        <= h;
    asset_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transaction(act, h, idx);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // hold off until every frame result is back and the last load or restart has retired
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_ASSET_COUNT: cfg_assets       = value[ASSET_CNT_W-1:0];
      REG_MAX_DSUM:    cfg_dsum_limit   = value[MAX_DSUM_W-1:0];
      REG_MAX_SPREAD:  cfg_spread_limit = value[MAX_SPR_W-1:0];
      REG_MIN_RUN:     cfg_run_min      = value[MIN_RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned assets, input int unsigned dsum_lim,
                                input int unsigned spread_lim, input int unsigned run_min);
    wait_quiet();
    write_reg(REG_ASSET_COUNT, CFG_W'(assets));
    write_reg(REG_MAX_DSUM, CFG_W'(dsum_lim));
    write_reg(REG_MAX_SPREAD, CFG_W'(spread_lim));
    write_reg(REG_MIN_RUN, CFG_W'(run_min));
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_settings();
    int unsigned dsum_lim, spread_lim, run_min;
    case ($urandom_range(3))
      0: dsum_lim = MAX_DSUM_RST;
      1: dsum_lim = 2047;
      2: dsum_lim = $urandom_range(40, 200);
      default: dsum_lim = $urandom_range(2047);
    endcase
    case ($urandom_range(3))
      0: spread_lim = MAX_SPREAD_RST;
      1: spread_lim = SPREAD_TOP;
      2: spread_lim = $urandom_range(20000);
      default: spread_lim = $urandom_range(SPREAD_TOP);
    endcase
    case ($urandom_range(3))
      0: run_min = $urandom_range(4);
      1: run_min = $urandom_range(5, 20);
      2: run_min = MIN_RUN_RST;
      default: run_min = $urandom_range(4095);
    endcase
    apply_settings($urandom_range(1, 24), dsum_lim, spread_lim, run_min);
  endtask

  task automatic test_basic_distances();
    send_item(ACT_LOAD, '0, '0);
    send_item(ACT_COMPARE, '0, '0);
    send_item(ACT_COMPARE, '1, '1);
    send_item(ACT_LOAD, '1, '1);
    send_item(ACT_LOAD, {32{2'b10}}, INDEX_W'(1));
    send_item(ACT_LOAD, {32{2'b01}}, INDEX_W'(2));
    send_item(ACT_UNUSED, {$urandom, $urandom}, INDEX_W'($urandom));
    send_item(ACT_COMPARE, {{32{1'b0}}, {32{1'b1}}}, '0);
    send_item(ACT_RESTART, '1, '1);
    send_item(ACT_COMPARE, HASH_W'(1), '0);
    apply_settings(3, MAX_DSUM_RST, MAX_SPREAD_RST, MIN_RUN_RST);
    send_item(ACT_COMPARE, {32{2'b10}}, '0);
    send_item(ACT_COMPARE, {32{2'b01}}, '0);
    send_item(ACT_COMPARE, {1'b1, {(HASH_W-1){1'b0}}}, '0);
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < FILL_DEPTH; i++)
      send_item(ACT_LOAD, {$urandom, $urandom}, INDEX_W'(i));
  endtask

  task automatic test_threshold_extremes();
    // zero run length behaves as one, so the first full window latches
    apply_settings(1, 2047, SPREAD_TOP, 0);
    send_item(ACT_RESTART, '0, '0);
    repeat (WIN + 2) send_item(ACT_COMPARE, ref_table[0], '0);
    apply_settings(1, 0, 0, 1);
    send_item(ACT_RESTART, '0, '0);
    repeat (WIN + 2) send_item(ACT_COMPARE, ref_table[0], '0);
    apply_settings(0, MAX_DSUM_RST, MAX_SPREAD_RST, MIN_RUN_RST);
    repeat (3) send_item(ACT_COMPARE, {$urandom, $urandom}, '0);
    apply_settings(FILL_DEPTH, MAX_DSUM_RST, MAX_SPREAD_RST, MIN_RUN_RST);
    send_item(ACT_COMPARE, ref_table[FILL_DEPTH-1], '0);
    send_item(ACT_COMPARE, {$urandom, $urandom}, '0);
  endtask

  // no references: every distance is full width, spread is zero, every full window is good
  task automatic test_long_run();
    apply_settings(0, 2047, 1, 40);
    send_item(ACT_RESTART, '0, '0);
    repeat (WIN + 48) send_item(ACT_COMPARE, {$urandom, $urandom}, '0);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned hold_pct,
                                  input int unsigned quota);
    int unsigned stop_at, next_retune, base, flips, burst, pick;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    stop_at       = items_sent + quota;
    next_retune   = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_retune) begin
        randomize_settings();
        next_retune = items_sent + $urandom_range(40, 80);
      end
      if ($urandom_range(3) == 0) send_item(ACT_RESTART, {$urandom, $urandom}, INDEX_W'($urandom));
      base  = $urandom_range(cfg_assets - 1);
      flips = $urandom_range(6);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 84)
          send_item(ACT_COMPARE, perturb(ref_table[base], flips + $urandom_range(1)),
                    INDEX_W'($urandom));
        else if (pick < 89)
          send_item(ACT_COMPARE, {$urandom, $urandom}, INDEX_W'($urandom));
        else if (pick < 94)
          send_item(ACT_LOAD, {$urandom, $urandom}, INDEX_W'($urandom));
        else if (pick < 97)
          send_item(ACT_UNUSED, {$urandom, $urandom}, INDEX_W'($urandom));
        else
          send_item(ACT_RESTART, {$urandom, $urandom}, INDEX_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin : check_verdicts
    frame_verdict_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{min_distance, window_valid, window_good, match_found, match_frame};
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected frame result: dist %0d valid %0b good %0b found %0b frame %0d",
                     got.min_distance, got.window_valid, got.window_good, got.match_found,
                     got.match_frame);
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          if (want.window_good) good_windows++;
          if (want.match_found) matched_verdicts++;
          if (got.min_distance !== want.min_distance || got.window_valid !== want.window_valid ||
              got.window_good !== want.window_good || got.match_found !== want.match_found ||
              got.match_frame !== want.match_frame) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected dist %0d valid %0b good %0b found %0b %s",
                       verdicts_checked, want.min_distance, want.window_valid, want.window_good,
                       want.match_found, $sformatf("frame %0d, got dist %0d valid %0b good %0b %s",
                       want.match_frame, got.min_distance, got.window_valid, got.window_good,
                       $sformatf("found %0b frame %0d", got.match_found, got.match_frame)));
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    clear_stream();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_distances();
    test_table_fill();
    test_threshold_extremes();
    test_long_run();
    run_random_phase(0, 0, 90);
    run_random_phase(55, 0, 90);
    run_random_phase(0, 55, 90);
    run_random_phase(31, 31, 90);
    wait_quiet();
    repeat (48) @(posedge clk);
    $display("sent %0d loads, compares and restarts; checked %0d frame results", items_sent,
             verdicts_checked);
    $display("%0d good windows, %0d results with a latched match, %0d failures", good_windows,
             matched_verdicts, fail_count);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
